@@ sv/i2c_mbe_pkg.sv @@
// Shared types and constants for the I2C master byte engine.
package i2c_mbe_pkg;

	// Bits moved per byte command
	localparam int unsigned BITS_PER_BYTE = 8;

	// Register widths and reset values
	localparam int unsigned UNIT_W       = 16;
	localparam int unsigned POLL_W       = 8;
	localparam int unsigned DELAY_W      = 19;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam logic [UNIT_W-1:0] UNIT_TICKS_RST     = 16'd100;
	localparam logic [POLL_W-1:0] ACK_POLL_LIMIT_RST = 8'd250;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 1'd1;

	// Command codes
	localparam logic [2:0] OP_START    = 3'd0;
	localparam logic [2:0] OP_STOP     = 3'd1;
	localparam logic [2:0] OP_WRITE    = 3'd2;
	localparam logic [2:0] OP_READ     = 3'd3;
	localparam logic [2:0] OP_WAIT_ACK = 3'd4;

	// One tick in: optional command plus the SDA sample
	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] op;
		logic [7:0] tx_byte;
		logic       ack_after_read;
		logic       sda_sample;
	} in_item_t;

	// One tick out: line levels and status
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_error;
	} out_item_t;

endpackage

@@ sv/i2c_master_byte_engine.sv @@
// I2C master byte engine: line sequencer stepped by one input beat per bus tick.
//
// Every input beat is one bus tick: it carries the sampled SDA level and,
// while the engine is idle, an optional command (start, stop, write byte,
// read byte, wait acknowledge). Each beat yields exactly one result beat with
// the SCL/SDA line state, busy, done, the last received byte and the
// acknowledge error flag. The tick is worked combinationally, so one beat
// is accepted per cycle while in_stall is low; a two-entry output (result
// register plus skid register) lets input keep flowing while a result
// waits, and in_stall rises only once both entries hold results. All bus
// timing counts beats, not clocks: each delay unit is unit_ticks beats.
module i2c_master_byte_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  i2c_mbe_pkg::in_item_t                in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output i2c_mbe_pkg::out_item_t               out_data,
	input  logic                                 cfg_we,
	input  logic [i2c_mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [i2c_mbe_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import i2c_mbe_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_S_SDA, PH_S_END, PH_P_HI, PH_P_END, PH_W_HI, PH_W_LO,
		PH_W_NEXT, PH_R_HI, PH_R_NEXT, PH_RA_HI, PH_RA_END, PH_A_HI, PH_A_POLL
	} phase_t;

	typedef struct packed {
		phase_t             phase;
		logic [2:0]         cur_op;
		logic [7:0]         shift;
		logic [3:0]         bit_cnt;
		logic [DELAY_W-1:0] delay;
		logic [POLL_W-1:0]  poll;
		logic               ack_mode;
		logic               scl;
		logic               sda;
		logic               drv;
		logic [7:0]         rx;
		logic               err;
	} core_t;

	logic [UNIT_W-1:0]  unit_q;
	logic [POLL_W-1:0]  limit_q;
	core_t              st_q;
	core_t              st_d;
	logic               done_d;
	logic [DELAY_W-1:0] dly1, dly2, dly4;
	logic [POLL_W:0]    poll_inc;
	out_item_t          res_d;
	out_item_t          res_q;
	out_item_t          skid_q;
	logic               res_valid_q;
	logic               skid_valid_q;
	logic               in_acc;
	logic               res_free;

	// Delay loads in beats for 1, 2 and 4 units
	assign dly1     = DELAY_W'(unit_q);
	assign dly2     = DELAY_W'(unit_q) << 1;
	assign dly4     = DELAY_W'(unit_q) << 2;
	assign poll_inc = {1'b0, st_q.poll} + 1'b1;

	// Handshake: input stalls only with both output entries full
	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid && !skid_valid_q;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;
	assign res_free  = !res_valid_q || !out_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q  <= UNIT_TICKS_RST;
			limit_q <= ACK_POLL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UNIT_TICKS:     unit_q  <= cfg_data;
				CFG_ACK_POLL_LIMIT: limit_q <= cfg_data[POLL_W-1:0];
				default: ;
			endcase
		end
	end

	// One bus tick of the sequencer
	always_comb begin
		st_d   = st_q;
		done_d = 1'b0;
		if (st_q.phase == PH_IDLE) begin
			if (in_data.cmd_valid && in_data.op <= OP_WAIT_ACK) begin
				st_d.err    = 1'b0;
				st_d.cur_op = in_data.op;
				case (in_data.op)
					OP_START: begin
						st_d.drv = 1'b1; st_d.sda = 1'b1; st_d.scl = 1'b1;
						st_d.delay = dly4; st_d.phase = PH_S_SDA;
					end
					OP_STOP: begin
						st_d.drv = 1'b1; st_d.scl = 1'b0; st_d.sda = 1'b0;
						st_d.delay = dly4; st_d.phase = PH_P_HI;
					end
					OP_WRITE: begin
						// first bit goes out on the accepting tick
						st_d.drv     = 1'b1;
						st_d.scl     = 1'b0;
						st_d.sda     = in_data.tx_byte[7];
						st_d.shift   = {in_data.tx_byte[6:0], 1'b0};
						st_d.bit_cnt = 4'd1;
						st_d.delay   = dly2;
						st_d.phase   = PH_W_HI;
					end
					OP_READ: begin
						st_d.drv = 1'b0; st_d.ack_mode = in_data.ack_after_read;
						st_d.shift = '0; st_d.bit_cnt = '0; st_d.scl = 1'b0;
						st_d.delay = dly2; st_d.phase = PH_R_HI;
					end
					default: begin
						st_d.drv = 1'b0; st_d.sda = 1'b1; st_d.poll = '0;
						st_d.delay = dly1; st_d.phase = PH_A_HI;
					end
				endcase
			end
		end else if (st_q.delay != '0) begin
			st_d.delay = st_q.delay - 1'b1;
		end else begin
			case (st_q.phase)
				PH_S_SDA: begin
					st_d.sda = 1'b0; st_d.delay = dly4; st_d.phase = PH_S_END;
				end
				PH_S_END: begin
					st_d.scl = 1'b0; st_d.phase = PH_IDLE; done_d = 1'b1;
				end
				PH_P_HI: begin
					st_d.scl = 1'b1; st_d.sda = 1'b1;
					st_d.delay = dly4; st_d.phase = PH_P_END;
				end
				PH_P_END: begin
					// stop issued by a timed-out acknowledge wait flags the error
					if (st_q.cur_op == OP_WAIT_ACK) st_d.err = 1'b1;
					st_d.phase = PH_IDLE; done_d = 1'b1;
				end
				PH_W_HI: begin
					st_d.scl = 1'b1; st_d.delay = dly2; st_d.phase = PH_W_LO;
				end
				PH_W_LO: begin
					st_d.scl = 1'b0; st_d.delay = dly2; st_d.phase = PH_W_NEXT;
				end
				PH_W_NEXT: begin
					if (st_q.bit_cnt >= 4'(BITS_PER_BYTE)) begin
						st_d.phase = PH_IDLE; done_d = 1'b1;
					end else begin
						st_d.scl     = 1'b0;
						st_d.sda     = st_q.shift[7];
						st_d.shift   = {st_q.shift[6:0], 1'b0};
						st_d.bit_cnt = st_q.bit_cnt + 1'b1;
						st_d.delay   = dly2;
						st_d.phase   = PH_W_HI;
					end
				end
				PH_R_HI: begin
					st_d.scl     = 1'b1;
					st_d.shift   = {st_q.shift[6:0], in_data.sda_sample};
					st_d.bit_cnt = st_q.bit_cnt + 1'b1;
					st_d.delay   = dly1;
					st_d.phase   = PH_R_NEXT;
				end
				PH_R_NEXT: begin
					st_d.scl   = 1'b0;
					st_d.delay = dly2;
					if (st_q.bit_cnt < 4'(BITS_PER_BYTE)) begin
						st_d.phase = PH_R_HI;
					end else begin
						st_d.drv   = 1'b1;
						st_d.sda   = !st_q.ack_mode;
						st_d.phase = PH_RA_HI;
					end
				end
				PH_RA_HI: begin
					st_d.scl = 1'b1; st_d.delay = dly2; st_d.phase = PH_RA_END;
				end
				PH_RA_END: begin
					st_d.scl = 1'b0; st_d.rx = st_q.shift;
					st_d.phase = PH_IDLE; done_d = 1'b1;
				end
				PH_A_HI: begin
					st_d.scl = 1'b1; st_d.delay = dly1; st_d.phase = PH_A_POLL;
				end
				PH_A_POLL: begin
					if (!in_data.sda_sample) begin
						st_d.scl = 1'b0; st_d.phase = PH_IDLE; done_d = 1'b1;
					end else if (poll_inc > {1'b0, limit_q}) begin
						// timeout: fall into the stop sequence
						st_d.drv = 1'b1; st_d.scl = 1'b0; st_d.sda = 1'b0;
						st_d.delay = dly4; st_d.phase = PH_P_HI;
					end else begin
						st_d.poll = poll_inc[POLL_W-1:0];
					end
				end
				default: st_d.phase = PH_IDLE;
			endcase
		end
	end

	// Result beat for this tick
	always_comb begin
		res_d.scl_level = st_d.scl;
		res_d.sda_level = st_d.sda;
		res_d.sda_drive = st_d.drv;
		res_d.busy_res  = (st_d.phase != PH_IDLE);
		res_d.done_res  = done_d;
		res_d.rx_byte   = st_d.rx;
		res_d.ack_error = st_d.err;
	end

	// Sequencer state plus result and skid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase    <= PH_IDLE;
			st_q.cur_op   <= '0;
			st_q.shift    <= '0;
			st_q.bit_cnt  <= '0;
			st_q.delay    <= '0;
			st_q.poll     <= '0;
			st_q.ack_mode <= 1'b0;
			st_q.scl      <= 1'b1;
			st_q.sda      <= 1'b1;
			st_q.drv      <= 1'b1;
			st_q.rx       <= '0;
			st_q.err      <= 1'b0;
			res_valid_q   <= 1'b0;
			skid_valid_q  <= 1'b0;
		end else begin
			if (in_acc) st_q <= st_d;
			if (res_free) begin
				if (skid_valid_q) begin
					res_q        <= skid_q;
					res_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					res_q       <= res_d;
					res_valid_q <= in_acc;
				end
			end else if (in_acc) begin
				skid_q       <= res_d;
				skid_valid_q <= 1'b1;
			end
		end
	end

endmodule

@@ sv/i2c_mbe_checker.sv @@
// Port-level checker for the I2C master byte engine, bound to the top level.
module i2c_mbe_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input i2c_mbe_pkg::out_item_t out_data
);
	// A completing beat leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done beat still busy");

	// A timed-out acknowledge ends with the bus stopped and idle
	a_err_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ack_error |->
		out_data.scl_level && out_data.sda_level && out_data.sda_drive
		&& !out_data.busy_res)
		else $error("error flag without a stopped bus");

	// Input only backs up when a result is waiting
	a_stall_needs_res: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2c_mbe_checker u_i2c_mbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
